/* hw/rtl/knn_classifier_core_assert.svh */
// Assertion macros for the classifier core. The property is sampled on the rising
// edge of clk and is disabled while rst_n is low.
`ifndef KNN_CLASSIFIER_CORE_ASSERT_SVH
`define KNN_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTH
`define KNN_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define KNN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define KNN_ASSERT(lbl, cond, msg)
`define KNN_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/knn_pkg.sv */
package knn_pkg;

    localparam int LABEL_W   = 2;
    localparam int K_W       = 5;
    localparam int STATUS_W  = 2;
    localparam int ACTION_W  = 2;
    localparam int MAX_K       = 16;
    localparam int NUM_CLASSES = 3;
    localparam logic [K_W-1:0] K_RESET = 5'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_VOTE,
        ST_PICK,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/knn_classifier_core.sv */
// Add, clear and unused actions place their result word in the cycle after accept.
// A query over the stored points runs the scan and distance pipeline, then a vote pass
// (one neighbour a cycle), then a winner pass over the classes, then the result word.
// One item at a time; the scan reads one store entry per cycle from one port.
// Reset (rst_n, async low) clears the point count, the kept count, tallies and k (to 3).
// Store contents are not cleared; only entries below the point count are ever read.
`include "knn_classifier_core_assert.svh"

module knn_classifier_core #(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, lowest bit up: point_x, point_y, point_class, zero fill
    input  logic [((2 * COORD_WIDTH + knn_pkg::LABEL_W + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: action
    input  logic [knn_pkg::ACTION_W-1:0] s_tuser,
    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, lowest bit up: predicted_class, neighbours_used, zero fill
    output logic [7:0]             m_tdata,
    // m_tuser: status
    output logic [knn_pkg::STATUS_W-1:0] m_tuser,
    // configuration: k_neighbours
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [knn_pkg::K_W-1:0] cfg_data
);

    localparam int MAX_K       = knn_pkg::MAX_K;
    localparam int NUM_CLASSES = knn_pkg::NUM_CLASSES;
    localparam int ADDR_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int IDX_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CLS_W    = $clog2(NUM_CLASSES);
    localparam int SQ_W     = 2 * COORD_WIDTH;
    localparam int DIST_W   = SQ_W + 1;
    localparam int K_W      = knn_pkg::K_W;
    localparam int LABEL_W  = knn_pkg::LABEL_W;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [LABEL_W-1:0]     label;
    } point_t;

    // ---------------------------------------------------------------------------
    // Input field split
    // ---------------------------------------------------------------------------
    logic [COORD_WIDTH-1:0] in_x;
    logic [COORD_WIDTH-1:0] in_y;
    logic [LABEL_W-1:0]     in_class;
    logic [LABEL_W-1:0]     in_label;
    knn_pkg::action_t       in_action;

    assign in_x      = s_tdata[COORD_WIDTH-1:0];
    assign in_y      = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign in_class  = s_tdata[2*COORD_WIDTH+LABEL_W-1:2*COORD_WIDTH];
    assign in_action = knn_pkg::action_t'(s_tuser);

    // Clamp an out-of-range label to the top class.
    assign in_label = (int'(in_class) >= NUM_CLASSES) ? LABEL_W'(NUM_CLASSES - 1) : in_class;

    // ---------------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------------
    knn_pkg::state_t        state_reg, state_next;
    logic [K_W-1:0]         k_reg;
    logic [CNT_W-1:0]       train_count_reg;
    logic [ADDR_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]       vote_idx_reg;
    logic [CLS_W-1:0]       pick_cls_reg;
    logic [CLS_W-1:0]       win_reg;
    logic [K_W-1:0]         win_cnt_reg;
    logic [K_W-1:0]         filled_reg;
    logic [K_W-1:0]         tally_reg [NUM_CLASSES];
    logic [COORD_WIDTH-1:0] qx_reg;
    logic [COORD_WIDTH-1:0] qy_reg;

    // distance pipeline: read data, magnitudes, squares, sum
    logic                   rd_v_reg, s1_v_reg, s2_v_reg, s3_v_reg;
    point_t                 rd_pt_reg;
    logic [COORD_WIDTH-1:0] s1_ax_reg, s1_ay_reg;
    logic [LABEL_W-1:0]     s1_lab_reg, s2_lab_reg, s3_lab_reg;
    logic [SQ_W-1:0]        s2_sx_reg, s2_sy_reg;
    logic [DIST_W-1:0]      s3_dist_reg;

    // kept-neighbour list, sorted by distance
    logic [DIST_W-1:0]      best_dist_reg [MAX_K];
    logic [LABEL_W-1:0]     best_lab_reg  [MAX_K];

    // result register
    logic                   m_tvalid_reg;
    knn_pkg::status_t       out_status_reg;
    logic [1:0]             out_class_reg;
    logic [4:0]             out_used_reg;

    // point store
    point_t                 train_mem [MAX_POINTS];

    // ---------------------------------------------------------------------------
    // Effective k: zero acts as one, above MAX_K acts as MAX_K
    // ---------------------------------------------------------------------------
    logic [K_W-1:0] k_eff;

    always_comb
    begin
        if (k_reg == '0)
            k_eff = K_W'(1);
        else if (int'(k_reg) > MAX_K)
            k_eff = K_W'(MAX_K);
        else
            k_eff = k_reg;
    end

    // ---------------------------------------------------------------------------
    // Control decode
    // ---------------------------------------------------------------------------
    logic accept;
    logic out_free;
    logic store_full;
    logic scan_issue;
    logic scan_last;
    logic vote_last;
    logic pick_last;
    logic pipe_empty;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign store_full = (int'(train_count_reg) >= MAX_POINTS);
    assign scan_last  = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == train_count_reg;
    assign vote_last  = (K_W'(vote_idx_reg) + K_W'(1)) == filled_reg;
    assign pick_last  = (int'(pick_cls_reg) == NUM_CLASSES - 1);
    assign pipe_empty = !rd_v_reg && !s1_v_reg && !s2_v_reg && !s3_v_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            knn_pkg::ST_IDLE:
            begin
                if (accept && in_action == knn_pkg::ACT_QUERY && train_count_reg != '0)
                    state_next = knn_pkg::ST_SCAN;
            end
            knn_pkg::ST_SCAN:
            begin
                if (scan_last)
                    state_next = knn_pkg::ST_DRAIN;
            end
            knn_pkg::ST_DRAIN:
            begin
                if (pipe_empty)
                    state_next = knn_pkg::ST_VOTE;
            end
            knn_pkg::ST_VOTE:
            begin
                if (vote_last)
                    state_next = knn_pkg::ST_PICK;
            end
            knn_pkg::ST_PICK:
            begin
                if (pick_last)
                    state_next = knn_pkg::ST_DONE;
            end
            knn_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = knn_pkg::ST_IDLE;
            end
            default:
                state_next = knn_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        scan_issue = 1'b0;
        unique case (state_reg)
            knn_pkg::ST_IDLE:  s_tready   = out_free;
            knn_pkg::ST_SCAN:  scan_issue = 1'b1;
            default:
            begin
                s_tready   = 1'b0;
                scan_issue = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------------------
    // Point store: one write port (add), one registered read port (scan)
    // ---------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && in_action == knn_pkg::ACT_ADD && !store_full)
            train_mem[train_count_reg[ADDR_W-1:0]] <= '{x: in_x, y: in_y, label: in_label};
        if (scan_issue)
            rd_pt_reg <= train_mem[scan_idx_reg];
    end

    // ---------------------------------------------------------------------------
    // Distance pipeline
    // ---------------------------------------------------------------------------
    logic signed [COORD_WIDTH:0] dx, dy;
    logic [COORD_WIDTH:0]        mx, my;
    logic [DIST_W-1:0]           dist_sum;

    always_comb
    begin
        dx = $signed({rd_pt_reg.x[COORD_WIDTH-1], rd_pt_reg.x})
           - $signed({qx_reg[COORD_WIDTH-1], qx_reg});
        dy = $signed({rd_pt_reg.y[COORD_WIDTH-1], rd_pt_reg.y})
           - $signed({qy_reg[COORD_WIDTH-1], qy_reg});
        mx = dx[COORD_WIDTH] ? (~dx + 1'b1) : dx;
        my = dy[COORD_WIDTH] ? (~dy + 1'b1) : dy;
        dist_sum = {1'b0, s2_sx_reg} + {1'b0, s2_sy_reg};
    end

    always_ff @(posedge clk)
    begin
        s1_ax_reg   <= mx[COORD_WIDTH-1:0];
        s1_ay_reg   <= my[COORD_WIDTH-1:0];
        s1_lab_reg  <= rd_pt_reg.label;
        s2_sx_reg   <= s1_ax_reg * s1_ax_reg;
        s2_sy_reg   <= s1_ay_reg * s1_ay_reg;
        s2_lab_reg  <= s1_lab_reg;
        s3_dist_reg <= dist_sum;
        s3_lab_reg  <= s2_lab_reg;
    end

    // ---------------------------------------------------------------------------
    // Sorted insert: a slot takes the new point where it is the first slot that is
    // empty or holds a strictly larger distance; later slots shift down by one.
    // Ties stay in scan order, and a full list drops its last entry.
    // ---------------------------------------------------------------------------
    logic [MAX_K-1:0] gt;
    logic             do_insert;

    always_comb
    begin
        for (int j = 0; j < MAX_K; j++)
            gt[j] = (j >= int'(filled_reg)) || (best_dist_reg[j] > s3_dist_reg);
    end

    assign do_insert = s3_v_reg && ((filled_reg < k_eff) || gt[IDX_W'(k_eff - K_W'(1))]);

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            for (int j = 0; j < MAX_K; j++)
            begin
                if (gt[j])
                begin
                    if (j == 0 || !gt[(j == 0) ? 0 : j - 1])
                    begin
                        best_dist_reg[j] <= s3_dist_reg;
                        best_lab_reg[j]  <= s3_lab_reg;
                    end
                    else
                    begin
                        best_dist_reg[j] <= best_dist_reg[(j == 0) ? 0 : j - 1];
                        best_lab_reg[j]  <= best_lab_reg[(j == 0) ? 0 : j - 1];
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Control and result registers
    // ---------------------------------------------------------------------------
    logic [LABEL_W-1:0] vote_lab;

    assign vote_lab = best_lab_reg[vote_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= knn_pkg::ST_IDLE;
            k_reg           <= knn_pkg::K_RESET;
            train_count_reg <= '0;
            scan_idx_reg    <= '0;
            vote_idx_reg    <= '0;
            pick_cls_reg    <= '0;
            win_reg         <= '0;
            win_cnt_reg     <= '0;
            filled_reg      <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
                tally_reg[c] <= '0;
            qx_reg          <= '0;
            qy_reg          <= '0;
            rd_v_reg        <= 1'b0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            s3_v_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            out_status_reg  <= knn_pkg::STAT_OK;
            out_class_reg   <= '0;
            out_used_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
                k_reg <= cfg_data;

            // advance the valid chain of the distance pipeline
            rd_v_reg <= scan_issue;
            s1_v_reg <= rd_v_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;

            // drop the result word once taken
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            if (accept)
            begin
                // default result for every action but a query on a filled store
                out_status_reg <= knn_pkg::STAT_OK;
                out_class_reg  <= '0;
                out_used_reg   <= '0;
                m_tvalid_reg   <= 1'b1;
                unique case (in_action)
                    knn_pkg::ACT_ADD:
                    begin
                        if (store_full)
                            out_status_reg <= knn_pkg::STAT_FULL;
                        else
                            train_count_reg <= train_count_reg + CNT_W'(1);
                    end
                    knn_pkg::ACT_CLEAR:
                        train_count_reg <= '0;
                    knn_pkg::ACT_QUERY:
                    begin
                        if (train_count_reg == '0)
                            out_status_reg <= knn_pkg::STAT_EMPTY;
                        else
                        begin
                            // hold the result word back until the query finishes
                            m_tvalid_reg <= 1'b0;
                            qx_reg       <= in_x;
                            qy_reg       <= in_y;
                            scan_idx_reg <= '0;
                            vote_idx_reg <= '0;
                            pick_cls_reg <= '0;
                            win_reg      <= '0;
                            win_cnt_reg  <= '0;
                            filled_reg   <= '0;
                            for (int c = 0; c < NUM_CLASSES; c++)
                                tally_reg[c] <= '0;
                        end
                    end
                    default:
                        out_status_reg <= knn_pkg::STAT_OK;
                endcase
            end

            if (scan_issue)
                scan_idx_reg <= scan_idx_reg + ADDR_W'(1);

            if (s3_v_reg && filled_reg < k_eff)
                filled_reg <= filled_reg + K_W'(1);

            // vote pass: one kept neighbour per cycle
            if (state_reg == knn_pkg::ST_VOTE)
            begin
                tally_reg[CLS_W'(vote_lab)] <= tally_reg[CLS_W'(vote_lab)] + K_W'(1);
                vote_idx_reg <= vote_idx_reg + IDX_W'(1);
            end

            // winner pass: one class per cycle, strict compare keeps the lowest class
            if (state_reg == knn_pkg::ST_PICK)
            begin
                if (tally_reg[pick_cls_reg] > win_cnt_reg)
                begin
                    win_reg     <= pick_cls_reg;
                    win_cnt_reg <= tally_reg[pick_cls_reg];
                end
                if (!pick_last)
                    pick_cls_reg <= pick_cls_reg + CLS_W'(1);
            end

            if (state_reg == knn_pkg::ST_DONE && out_free)
            begin
                m_tvalid_reg   <= 1'b1;
                out_status_reg <= knn_pkg::STAT_OK;
                out_class_reg  <= 2'(win_reg);
                out_used_reg   <= 5'(filled_reg);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_used_reg, out_class_reg};

    // ---------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------
    `KNN_ASSERT_IMP(a_filled_le_k, state_reg != knn_pkg::ST_IDLE,
        filled_reg <= k_eff, "kept list grew past k")
    `KNN_ASSERT(a_count_le_max, int'(train_count_reg) <= MAX_POINTS, "point count overflow")
    `KNN_ASSERT_IMP(a_insert_in_scan, s3_v_reg,
        state_reg == knn_pkg::ST_SCAN || state_reg == knn_pkg::ST_DRAIN,
        "distance arrived outside scan")
    `KNN_ASSERT_IMP(a_vote_in_range, state_reg == knn_pkg::ST_VOTE,
        K_W'(vote_idx_reg) < filled_reg, "vote index past kept list")
    `KNN_ASSERT_IMP(a_empty_no_votes, m_tvalid_reg && out_status_reg != knn_pkg::STAT_OK,
        out_used_reg == '0 && out_class_reg == '0, "error result carries votes")

endmodule
